/* rtl/ascm_pkg.sv */
// Package for the adaptive size-class mapper.
// Holds default sizing, fixed field widths and the fixed-class helper functions.
// No dependencies.
package ascm_pkg;

	localparam int unsigned SIZE_IN_W   = 32;
	localparam int unsigned CLASS_W     = 7;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned THR_W       = 4;
	localparam logic [THR_W-1:0] THR_RESET = 4'd10;
	localparam logic [SIZE_IN_W-1:0] SMALL_LIMIT = 32'd8;

	localparam int unsigned DEF_GRANULE_BYTES = 8;
	localparam int unsigned DEF_TRACKED_LIMIT = 65536;
	localparam int unsigned DEF_LEARNED_SLOTS = 64;
	localparam int unsigned DEF_BASE_CLASSES  = 64;

	// Half-power-of-two class: k = ceil(log2 x), 2k-1 if x <= 0.75*2^k else 2k.
	function automatic logic [CLASS_W-1:0] fixed_class(input logic [SIZE_IN_W-1:0] x);
		logic [SIZE_IN_W-1:0] t;
		logic [5:0]           k;
		logic [SIZE_IN_W:0]   v;
		logic [SIZE_IN_W:0]   lim;
		t = (x > 32'd1) ? x - 32'd1 : 32'd1;
		k = 6'd1;
		for (int i = 1; i < SIZE_IN_W; i++) begin
			if (t[i]) k = 6'(i + 1);
		end
		v   = 33'd1 << k;
		lim = v - (v >> 2);
		if ({1'b0, x} <= lim) return 7'({k, 1'b0} - 7'd1);
		else return 7'({k, 1'b0});
	endfunction

	// Byte size of a fixed class index.
	function automatic logic [SIZE_IN_W:0] class_size(input logic [CLASS_W-1:0] idx);
		logic [SIZE_IN_W:0] v;
		v = 33'd1 << idx[CLASS_W-1:1];
		return v + ((v >> 1) & {(SIZE_IN_W+1){idx[0]}});
	endfunction

endpackage

/* rtl/ascm_if.sv */
// Valid/ready channel interfaces for request and response.
// Depends on nothing; payload widths match ascm_pkg field widths.
interface ascm_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] request_size;
	logic        count_hit;
	modport source (output valid, output request_size, output count_hit, input ready);
	modport sink (input valid, input request_size, input count_hit, output ready);
endinterface

interface ascm_rsp_if;
	logic       valid;
	logic       ready;
	logic [6:0] class_index;
	logic       from_learned;
	modport source (output valid, output class_index, output from_learned, input ready);
	modport sink (input valid, input class_index, input from_learned, output ready);
endinterface

/* rtl/adaptive_size_class_mapper.sv */
// Adaptive size-class mapper, top level.
// Depends on ascm_pkg, ascm_if, ascm_granule_ram, ascm_slot_ram.
//
// Usage:
//  req channel (valid/ready): request_size in bytes and count_hit.
//  rsp channel (valid/ready): class_index and from_learned, one response per request.
//  cfg_we/cfg_wdata: writes learn_threshold (reset 10); write only while idle.
// Timing:
//  After reset the block sweeps the granule RAM clearing counters and the map,
//  one entry per cycle, TRACKED_LIMIT/GRANULE_BYTES entries (8192 by default).
//  req.ready stays low during that sweep.
//  From accept to response valid a request passes decode, granule RAM read and
//  resolve into the output register for fixed and counted sizes, plus a check
//  state when an already learned slot's size is checked in the slot RAM. Learning
//  a new class adds a slot RAM scan over the earlier slots and a map fill over
//  each granule in the new range; these set the worst case latency.
//  One request at a time; back in idle the next is accepted.
// Stall: the response sits in an output register; a new request is taken while
//  it waits, but its result holds in the resolve state until the register frees.
module adaptive_size_class_mapper #(
	parameter int unsigned GRANULE_BYTES = ascm_pkg::DEF_GRANULE_BYTES,
	parameter int unsigned TRACKED_LIMIT = ascm_pkg::DEF_TRACKED_LIMIT,
	parameter int unsigned LEARNED_SLOTS = ascm_pkg::DEF_LEARNED_SLOTS,
	parameter int unsigned BASE_CLASSES  = ascm_pkg::DEF_BASE_CLASSES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ascm_req_if.sink                     req,
	ascm_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [ascm_pkg::THR_W-1:0]   cfg_wdata
);
	localparam int unsigned GRAN_W    = $clog2(GRANULE_BYTES);
	localparam int unsigned MAP_DEPTH = TRACKED_LIMIT / GRANULE_BYTES;
	localparam int unsigned AW        = $clog2(MAP_DEPTH);
	localparam int unsigned SIZE_W    = AW + GRAN_W;
	localparam int unsigned SLOT_W    = $clog2(LEARNED_SLOTS);
	localparam int unsigned IW        = ascm_pkg::SIZE_IN_W;
	localparam int unsigned CW        = ascm_pkg::CLASS_W;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_READ, S_CHECK, S_SCAN, S_FILL, S_DONE
	} state_t;

	state_t                     state_q;
	logic [IW-1:0]              size_q;
	logic                       hit_q;
	logic [CW-1:0]              fc_q;
	logic                       track_q;
	logic [AW-1:0]              g_q;
	logic [SIZE_W-1:0]          near_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [AW-1:0]              ptr_q;
	logic [SLOT_W:0]            scan_q;
	logic                       scan_vld_q;
	logic [SLOT_W:0]            next_free_q;
	logic [ascm_pkg::THR_W-1:0] thr_q;
	logic [CW-1:0]              res_class_q;
	logic                       res_learned_q;
	logic                       out_valid_q;
	logic [CW-1:0]              out_class_q;
	logic                       out_learned_q;

	// granule RAM ports
	logic                       g_rd_en;
	logic [AW-1:0]              g_rd_addr;
	logic [ascm_pkg::CNT_W-1:0] cnt_rd;
	logic [SLOT_W-1:0]          map_rd;
	logic [AW-1:0]              g_wr_addr;
	logic                       cnt_we;
	logic [ascm_pkg::CNT_W-1:0] cnt_wd;
	logic                       map_we;
	logic [SLOT_W-1:0]          map_wd;
	// slot RAM ports
	logic [SLOT_W-1:0]          s_rd_addr;
	logic [SIZE_W-1:0]          s_rd_data;
	logic                       s_we;

	// decode of the held request
	logic                       is_small, is_pow2;
	logic [IW:0]                rup;
	logic                       dec_track;
	logic [SIZE_W-1:0]          rounded;
	logic                       scan_issue;
	logic [CW-1:0]              learned_class;

	assign is_small  = size_q <= ascm_pkg::SMALL_LIMIT;
	assign is_pow2   = (size_q & (size_q - 1'b1)) == '0;
	assign rup       = ({1'b0, size_q} + (IW+1)'(GRANULE_BYTES - 1)) >> GRAN_W;
	assign dec_track = !is_small && !is_pow2 && (rup < (IW+1)'(MAP_DEPTH));
	assign rounded   = {g_q, {GRAN_W{1'b0}}};
	assign scan_issue = scan_q < {1'b0, slot_q};
	assign learned_class = CW'(BASE_CLASSES + slot_q);

	ascm_granule_ram #(.DEPTH(MAP_DEPTH), .SLOT_W(SLOT_W)) u_granule (
		.clk, .rd_en(g_rd_en), .rd_addr(g_rd_addr), .cnt_rd, .map_rd,
		.wr_addr(g_wr_addr), .cnt_we, .cnt_wd, .map_we, .map_wd
	);

	ascm_slot_ram #(.SLOTS(LEARNED_SLOTS), .SIZE_W(SIZE_W)) u_slots (
		.clk, .rd_addr(s_rd_addr), .rd_data(s_rd_data),
		.we(s_we), .wr_addr(next_free_q[SLOT_W-1:0]), .wr_data(rounded)
	);

	// memory control
	always_comb begin
		g_rd_en   = state_q == S_DECODE;
		g_rd_addr = rup[AW-1:0];
		g_wr_addr = ptr_q;
		cnt_we    = 1'b0;
		cnt_wd    = '0;
		map_we    = 1'b0;
		map_wd    = '0;
		s_we      = 1'b0;
		s_rd_addr = scan_q[SLOT_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				cnt_we = 1'b1;
				map_we = 1'b1;
			end
			S_READ: begin
				g_wr_addr = g_q;
				s_rd_addr = map_rd;
				// counter bump on a counted hit while below threshold
				if (track_q && cnt_rd < thr_q && hit_q) begin
					cnt_we = 1'b1;
					cnt_wd = cnt_rd + 1'b1;
				end
				// new slot claims its size entry
				if (track_q && cnt_rd >= thr_q && map_rd == '0 &&
				    next_free_q < (SLOT_W+1)'(LEARNED_SLOTS))
					s_we = 1'b1;
			end
			S_FILL: begin
				map_we = 1'b1;
				map_wd = slot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			ptr_q         <= '0;
			next_free_q   <= (SLOT_W+1)'(1);
			thr_q         <= ascm_pkg::THR_RESET;
			out_valid_q   <= 1'b0;
			scan_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			// S_DONE reloads the register itself
			if (out_valid_q && rsp.ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == AW'(MAP_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						size_q  <= req.request_size;
						hit_q   <= req.count_hit;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					fc_q    <= ascm_pkg::fixed_class(size_q);
					track_q <= dec_track;
					g_q     <= rup[AW-1:0];
					state_q <= S_READ;
				end
				S_READ: begin
					res_class_q   <= fc_q;
					res_learned_q <= 1'b0;
					priority if (!track_q || cnt_rd < thr_q) begin
						state_q <= S_DONE;
					end else if (map_rd != '0) begin
						slot_q  <= map_rd;
						state_q <= S_CHECK;
					end else if (next_free_q >= (SLOT_W+1)'(LEARNED_SLOTS)) begin
						state_q <= S_DONE;
					end else begin
						slot_q     <= next_free_q[SLOT_W-1:0];
						near_q     <= SIZE_W'(ascm_pkg::class_size(
						              ascm_pkg::fixed_class(IW'(rounded)) - 1'b1));
						scan_q     <= (SLOT_W+1)'(1);
						scan_vld_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_CHECK: begin
					// larger learned size owns this granule: stay fixed
					if (s_rd_data <= rounded) begin
						res_class_q   <= learned_class;
						res_learned_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (scan_issue) scan_q <= scan_q + 1'b1;
					scan_vld_q <= scan_issue;
					if (scan_vld_q && s_rd_data < rounded && s_rd_data > near_q)
						near_q <= s_rd_data;
					if (!scan_issue && !scan_vld_q) begin
						ptr_q   <= AW'(near_q >> GRAN_W) + 1'b1;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (ptr_q == g_q) begin
						next_free_q   <= next_free_q + 1'b1;
						res_class_q   <= learned_class;
						res_learned_q <= 1'b1;
						state_q       <= S_DONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q   <= 1'b1;
						out_class_q   <= res_class_q;
						out_learned_q <= res_learned_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready        = state_q == S_IDLE;
	assign rsp.valid        = out_valid_q;
	assign rsp.class_index  = out_class_q;
	assign rsp.from_learned = out_learned_q;
endmodule

/* rtl/ascm_granule_ram.sv */
// Per-granule store: hit counters and granule-to-slot map.
// Synchronous RAM, one read port (registered), one write address. Uses ascm_pkg.
module ascm_granule_ram #(
	parameter int unsigned DEPTH  = 8192,
	parameter int unsigned SLOT_W = 6
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [ascm_pkg::CNT_W-1:0] cnt_rd,
	output logic [SLOT_W-1:0]         map_rd,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic                      cnt_we,
	input  logic [ascm_pkg::CNT_W-1:0] cnt_wd,
	input  logic                      map_we,
	input  logic [SLOT_W-1:0]         map_wd
);
	logic [ascm_pkg::CNT_W-1:0] cnt_mem [DEPTH];
	logic [SLOT_W-1:0]          map_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
		if (map_we) map_mem[wr_addr] <= map_wd;
		if (rd_en) begin
			cnt_rd <= cnt_mem[rd_addr];
			map_rd <= map_mem[rd_addr];
		end
	end
endmodule

/* rtl/ascm_slot_ram.sv */
// Learned slot size table, one entry per learned slot.
// Synchronous RAM, registered read. No package dependency.
module ascm_slot_ram #(
	parameter int unsigned SLOTS  = 64,
	parameter int unsigned SIZE_W = 16
) (
	input  logic                     clk,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output logic [SIZE_W-1:0]        rd_data,
	input  logic                     we,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  logic [SIZE_W-1:0]        wr_data
);
	logic [SIZE_W-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end
endmodule

/* dv/testbench.sv */
// Testbench for the adaptive size-class mapper: directed and random requests
// checked against an in-bench prediction of fixed and learned classes.
// Depends on ascm_pkg, ascm_if and the adaptive_size_class_mapper RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned GRAN      = ascm_pkg::DEF_GRANULE_BYTES;
	localparam int unsigned TRACK_LIM = ascm_pkg::DEF_TRACKED_LIMIT;
	localparam int unsigned SLOTS     = ascm_pkg::DEF_LEARNED_SLOTS;
	localparam int unsigned BASE      = ascm_pkg::DEF_BASE_CLASSES;
	localparam int unsigned GRANULES  = TRACK_LIM / GRAN + 1;
	// Must outlast the reset sweep and the longest learn fill.
	localparam int unsigned STALL_LIMIT = 40000;

	typedef struct packed {
		logic [ascm_pkg::CLASS_W-1:0] class_index;
		logic                         from_learned;
	} class_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ascm_pkg::THR_W-1:0] cfg_wdata = '0;

	ascm_req_if req_ch ();
	ascm_rsp_if rsp_ch ();

	adaptive_size_class_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Mirror of the block's state.
	logic [ascm_pkg::THR_W-1:0] model_threshold;
	logic [ascm_pkg::CNT_W-1:0] model_hits [GRANULES];
	int unsigned      model_map [GRANULES];
	longint unsigned  model_slot_size [SLOTS];
	int unsigned      model_next_slot;

	class_result_t expected_classes [$];
	int unsigned   error_count = 0;
	int unsigned   idle_cycles = 0;
	longint unsigned size_pool [$];

	// ceil(log2 x), with 0 and 1 both giving 1
	function automatic int unsigned size_log2(longint unsigned x);
		longint unsigned t;
		int unsigned msb;
		t = (x > 1) ? x - 1 : 1;
		msb = 0;
		while (t > 1) begin
			t = t >> 1;
			msb++;
		end
		return msb + 1;
	endfunction

	function automatic int unsigned half_pow2_class(longint unsigned x);
		int unsigned k;
		longint unsigned v;
		k = size_log2(x);
		v = 64'd1 << k;
		return (x <= v - v / 4) ? 2 * k - 1 : 2 * k;
	endfunction

	function automatic longint unsigned half_pow2_bytes(int unsigned idx);
		longint unsigned v;
		v = 64'd1 << (idx / 2);
		return v + (v / 2) * (idx % 2);
	endfunction

	// Returns 1 and the slot if the size resolves to a learned class; updates
	// counters and the granule map like the block does.
	function automatic bit learned_slot_of(longint unsigned size, bit hit,
			output int unsigned slot);
		longint unsigned rounded, near_size;
		int unsigned g, lo;
		slot = 0;
		if (size <= 8 || (size & (size - 1)) == 0) return 0;
		rounded = (size + GRAN - 1) / GRAN * GRAN;
		if (rounded >= TRACK_LIM) return 0;
		g = 32'(rounded / GRAN);
		if (model_hits[g] < model_threshold) begin
			if (hit) model_hits[g]++;
			return 0;
		end
		slot = model_map[g];
		if (slot >= SLOTS) return 0;
		if (slot != 0) return model_slot_size[slot] <= rounded;
		if (model_next_slot >= SLOTS) return 0;
		slot = model_next_slot;
		model_slot_size[slot] = rounded;
		// range starts above the nearest smaller learned size or fixed class
		near_size = half_pow2_bytes(half_pow2_class(rounded) - 1);
		for (int s = 0; s < slot; s++)
			if (model_slot_size[s] < rounded && model_slot_size[s] > near_size)
				near_size = model_slot_size[s];
		lo = 32'(near_size / GRAN + 1);
		for (int i = lo; i <= g && i < GRANULES; i++) model_map[i] = slot;
		model_next_slot++;
		return 1;
	endfunction

	function automatic class_result_t predict_class(logic [31:0] size, logic hit);
		class_result_t r;
		int unsigned slot;
		if (learned_slot_of(size, hit, slot)) begin
			r.class_index = ascm_pkg::CLASS_W'(BASE + slot);
			r.from_learned = 1'b1;
		end else begin
			r.class_index = ascm_pkg::CLASS_W'(half_pow2_class(size));
			r.from_learned = 1'b0;
		end
		return r;
	endfunction

	// Mostly short gaps, a few long ones; bursts with none.
	bit tx_burst = 1'b0;
	function automatic int unsigned pick_gap(bit burst);
		int unsigned p;
		if (burst) return 0;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Drive one request, hold until accepted, queue its prediction.
	task automatic send_request(logic [31:0] size, logic hit);
		int unsigned gap;
		req_ch.valid        <= 1'b1;
		req_ch.request_size <= size;
		req_ch.count_hit    <= hit;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_classes.push_back(predict_class(size, hit));
		if ($urandom_range(49) == 0) tx_burst = ~tx_burst;
		gap = pick_gap(tx_burst);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_classes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Threshold writes happen only with nothing in flight.
	task automatic write_threshold(logic [ascm_pkg::THR_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		model_threshold = value;
		cfg_we <= 1'b0;
	endtask

	// Mix: repeated pool sizes (reach learning), neighbors of pool sizes
	// (land inside a learned range), small sizes, powers of two, plus noise over the full 32 bits.
	function automatic logic [31:0] pick_size();
		int unsigned p;
		longint unsigned base_sz;
		p = $urandom_range(99);
		base_sz = size_pool[$urandom_range(size_pool.size() - 1)];
		if (p < 65) return 32'(base_sz);
		if (p < 75) return 32'(base_sz - $urandom_range(24, 1));
		if (p < 85) return $urandom_range(600, 9);
		if (p < 90) return 32'd1 << $urandom_range(31);
		return $urandom;
	endfunction

	task automatic test_directed();
		logic [31:0] sizes [$];
		sizes = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
			32'd16, 32'd17, 32'd1024, 32'd1025, 32'd65527, 32'd65528, 32'd65529,
			32'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
			32'h5555_5555};
		foreach (sizes[i]) send_request(sizes[i], 1'(i % 2));
	endtask

	// Threshold one: a size learns on its second sighting; check reuse.
	task automatic test_learn_quick();
		write_threshold(4'd1);
		send_request(32'd100, 1'b1);
		send_request(32'd100, 1'b1);
		send_request(32'd97, 1'b0);
		send_request(32'd90, 1'b0);
		send_request(32'd100, 1'b0);
	endtask

	task automatic test_random(logic [ascm_pkg::THR_W-1:0] thr, int unsigned count);
		write_threshold(thr);
		repeat (count) send_request(pick_size(), $urandom_range(99) < 85);
	endtask

	initial begin
		req_ch.valid        = 1'b0;
		req_ch.request_size = '0;
		req_ch.count_hit    = 1'b0;
		model_threshold = ascm_pkg::THR_RESET;
		model_next_slot = 1;
		foreach (model_hits[i]) model_hits[i] = '0;
		foreach (model_map[i]) model_map[i] = 0;
		foreach (model_slot_size[i]) model_slot_size[i] = 0;
		repeat (40) size_pool.push_back($urandom_range(2000, 9));
		repeat (8) size_pool.push_back($urandom_range(65527, 2001));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_learn_quick();
		test_random(ascm_pkg::THR_RESET, 200);
		test_random(4'd15, 100);
		test_random(4'd0, 100);
		test_random(4'd1, 150);
		test_random(4'd3, 200);

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Response side: random backpressure, compare each accepted response.
	int unsigned rx_stall = 0;
	always @(posedge clk) begin
		class_result_t exp_r;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_classes.size() == 0) begin
				$display("%0t: unexpected response class %0d learned %0b", $realtime,
					rsp_ch.class_index, rsp_ch.from_learned);
				error_count++;
			end else begin
				exp_r = expected_classes.pop_front();
				if (rsp_ch.class_index !== exp_r.class_index) begin
					$display("%0t: class_index expected %0d actual %0d", $realtime,
						exp_r.class_index, rsp_ch.class_index);
					error_count++;
				end
				if (rsp_ch.from_learned !== exp_r.from_learned) begin
					$display("%0t: from_learned expected %0b actual %0b", $realtime,
						exp_r.from_learned, rsp_ch.from_learned);
					error_count++;
				end
			end
		end
		if (rx_stall != 0) begin
			rx_stall <= rx_stall - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rx_stall <= pick_gap($urandom_range(3) == 0);
			rsp_ch.ready <= 1'b1;
		end
	end
	initial rsp_ch.ready = 1'b0;

	// Watchdog: too long with no request or response moving.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end
endmodule
